// ===== rtl/dqe_pkg.sv =====
// Shared types and constants of the DNS question encoder.
`default_nettype none

package dqe_pkg;

   // Question buffer size in bytes; writes at or beyond it are suppressed.
   localparam int unsigned BUF_BYTES = 512;

   localparam logic [7:0]  DOT_CHAR    = 8'h2E;
   localparam logic [9:0]  POS_MAX     = 10'd1023;
   localparam logic [7:0]  LEN_MAX     = 8'd255;
   localparam logic [15:0] CLASS_IN    = 16'd1;
   localparam logic [15:0] QTYPE_RESET = 16'd1;

   // Writes produced by the end mark, in order.
   localparam int unsigned SUB_W        = 3;
   localparam logic [SUB_W-1:0] SUB_LEN      = 3'd0;
   localparam logic [SUB_W-1:0] SUB_TERM     = 3'd1;
   localparam logic [SUB_W-1:0] SUB_TYPE_HI  = 3'd2;
   localparam logic [SUB_W-1:0] SUB_TYPE_LO  = 3'd3;
   localparam logic [SUB_W-1:0] SUB_CLASS_HI = 3'd4;
   localparam logic [SUB_W-1:0] SUB_CLASS_LO = 3'd5;

   // Transaction queue between the name tracker and the write expander.
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = 2;
   localparam int unsigned CNT_W      = 3;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [8:0] write_addr;
      logic [7:0] write_byte;
      logic       write_valid;
      logic       overflow;
      logic       run_last;
      logic       question_done;
      logic [9:0] total_length;
   } rsp_type;

   // One queued transaction: an ordinary write, or an end mark that expands to six.
   typedef struct packed {
      logic        end_mark;
      logic [10:0] first_addr;
      logic [7:0]  first_byte;
      logic [9:0]  pos;
      logic [15:0] qtype;
   } rec_type;

endpackage

`default_nettype wire

// ===== rtl/dns_question_encoder_top.sv =====
// Top level of the DNS question encoder: name tracking, queue and write expansion.
// A transaction's first write is registered in the queue and then in the output register.
// Throughput: one character per cycle while the queue has room; an end mark holds the write port for its six writes,
//   the four-entry queue takes three more characters, then a steady stream stalls.
// Reset (synchronous, active high): clears position and label length, sets the
//   query type to 1, empties the queue and drops any pending write.
`default_nettype none

module dns_question_encoder_top
   import dqe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   // ---------------------------------------------------------------
   // Configuration: query type; write it only while idle (the block does not enforce this).
   // ---------------------------------------------------------------
   logic [15:0] qtype_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qtype_ff <= QTYPE_RESET;
      end else if (csr_wr_en) begin
         qtype_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // Name tracking: position in the name and length of the open label.
   // Each accepted transaction is turned into one queue record here.
   // ---------------------------------------------------------------
   logic [9:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [9:0]  label_start;
   logic        req_accept;
   rec_type     rec_new;

   assign req_accept  = req_valid && req_ready;
   assign label_start = (pos_ff >= {2'b00, len_ff}) ? (pos_ff - {2'b00, len_ff}) : 10'd0;

   always_comb begin
      pos_in  = pos_ff;
      len_in  = len_ff;
      rec_new.end_mark   = req_data.last_char;
      rec_new.pos        = pos_ff;
      rec_new.qtype      = qtype_ff;
      rec_new.first_addr = {1'b0, label_start};
      rec_new.first_byte = len_ff;
      if (req_data.last_char) begin
         // End mark: the carried byte is ignored; close the name and start over.
         pos_in = 10'd0;
         len_in = 8'd0;
      end else begin
         if (req_data.char_byte == DOT_CHAR) begin
            // Dot: write the finished label's length back at its start.
            len_in = 8'd0;
         end else begin
            rec_new.first_addr = {1'b0, pos_ff} + 11'd1;
            rec_new.first_byte = req_data.char_byte;
            if (pos_ff < POS_MAX && len_ff < LEN_MAX) begin
               len_in = len_ff + 8'd1;
            end
         end
         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 10'd0;
         len_ff <= 8'd0;
      end else if (req_accept) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
      end
   end

   // ---------------------------------------------------------------
   // Transaction queue: absorbs characters while an end mark drains.
   // ---------------------------------------------------------------
   rec_type            fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               head_valid;
   logic               pop;
   rec_type            head;

   assign req_ready  = (count_ff != CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fifo_ff[wr_ptr_ff] <= rec_new;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_accept && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!req_accept && pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------
   // Write expander: one write per cycle from the queue head, unless the
   // output stalls. An end mark steps through its six writes with the sub-index counter.
   // ---------------------------------------------------------------
   logic [SUB_W-1:0] sub_ff, sub_in;
   logic [10:0]      exp_addr;
   logic [7:0]       exp_byte;
   logic             exp_last;
   logic             exp_done;
   logic [10:0]      total_sum;
   logic [9:0]       total_sat;
   logic             exp_inside;
   logic             rsp_load;
   rsp_type          rsp_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   assign total_sum = {1'b0, head.pos} + 11'd6;
   assign total_sat = (total_sum > {1'b0, POS_MAX}) ? POS_MAX : total_sum[9:0];

   always_comb begin
      exp_addr = head.first_addr;
      exp_byte = head.first_byte;
      exp_last = 1'b1;
      exp_done = 1'b0;
      if (head.end_mark) begin
         exp_addr = {1'b0, head.pos} + {8'd0, sub_ff};
         exp_last = 1'b0;
         unique case (sub_ff)
            SUB_LEN: begin
               exp_addr = head.first_addr;
               exp_byte = head.first_byte;
            end
            SUB_TERM:     exp_byte = 8'd0;
            SUB_TYPE_HI:  exp_byte = head.qtype[15:8];
            SUB_TYPE_LO:  exp_byte = head.qtype[7:0];
            SUB_CLASS_HI: exp_byte = CLASS_IN[15:8];
            SUB_CLASS_LO: begin
               exp_byte = CLASS_IN[7:0];
               exp_last = 1'b1;
               exp_done = 1'b1;
            end
            default:      exp_byte = 8'd0;
         endcase
      end
   end

   assign exp_inside = (32'(exp_addr) < BUF_BYTES);

   always_comb begin
      rsp_in.write_addr    = exp_addr[8:0];
      rsp_in.write_byte    = exp_byte;
      rsp_in.write_valid   = exp_inside;
      rsp_in.overflow      = !exp_inside;
      rsp_in.run_last      = exp_last;
      rsp_in.question_done = exp_done;
      rsp_in.total_length  = exp_done ? total_sat : 10'd0;
   end

   // Load the output register whenever it is empty or being drained.
   assign rsp_load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop      = rsp_load && (!head.end_mark || sub_ff == SUB_CLASS_LO);

   always_comb begin
      sub_in = sub_ff;
      if (pop) begin
         sub_in = SUB_LEN;
      end else if (rsp_load) begin
         sub_in = sub_ff + SUB_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= SUB_LEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/dqe_checker.sv =====
// Port-level checker for the DNS question encoder and its bind.
`default_nettype none

module dqe_checker
   import dqe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled write changed or vanished");

   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.write_valid != rsp_data.overflow)
      else $error("write_valid and overflow not exclusive");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.question_done |-> rsp_data.run_last)
      else $error("question_done without run_last");

   a_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.question_done |-> rsp_data.total_length == 10'd0)
      else $error("total_length set outside the final write");

endmodule

bind dns_question_encoder_top dqe_checker u_dqe_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
